/* src/level_meter_ballistics_defines.svh */
// ----------------------------------------------------------------------------
// level meter ballistics: assertion macros
// shared property wrappers, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef LEVEL_METER_BALLISTICS_DEFINES_SVH
`define LEVEL_METER_BALLISTICS_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define LMB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmb check failed");

// consequent holds in the cycle after the antecedent
`define LMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmb check failed");

`endif

/* src/lmb_pkg.sv */
// ----------------------------------------------------------------------------
// lmb_pkg
// shared types, constants and ballistics tables of the level meter
// ----------------------------------------------------------------------------
`default_nettype none

package lmb_pkg;

  localparam int LEVEL_BITS = 16;
  localparam int MAX_ZONES  = 8;
  localparam int NUM_BREAKS = MAX_ZONES - 1;
  localparam int BREAK_W    = 16;
  localparam int ZONE_W     = 3;
  localparam int ZC_W       = 4;
  localparam int MS_W       = 10;
  localparam int MS_CAP     = 100;
  localparam int MS_IDX_W   = $clog2(MS_CAP + 1);
  localparam int KW         = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int BRK_LOW_W  = 64;
  localparam int BRK_HIGH_W = 48;
  localparam int ROUND_POS  = 15;

  localparam longint unsigned VU_DECAY_Q32 = 64'd4229396560;
  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {LEVEL_BITS{1'b1}};

  // mode register codes
  localparam logic [1:0] MODE_EXACT     = 2'd0;
  localparam logic [1:0] MODE_VU        = 2'd1;
  localparam logic [1:0] MODE_HOLD      = 2'd2;
  localparam logic [1:0] MODE_EXACT_ALT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAKS_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAKS_HIGH = 3'd4;

  typedef enum logic [1:0] {
    OP_SET        = 2'd0,
    OP_TICK       = 2'd1,
    OP_PEAK_RESET = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [KW-1:0]         kfac_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic                  peak_enable;
    logic [ZC_W-1:0]       zone_count;
    logic [BRK_LOW_W-1:0]  breaks_low;
    logic [BRK_HIGH_W-1:0] breaks_high;
  } cfg_t;

  // one classified beat, as handed from front to back
  typedef struct packed {
    op_t    op;
    level_t val;
    logic   tick_nz;
    kfac_t  k;
    level_t fall_level;
    level_t fall_peak;
  } item_t;

  typedef kfac_t  k_tab_t    [0:MS_CAP];
  typedef level_t fall_tab_t [0:MS_CAP];

  // vu factor k = 1 - exp(-ms/65), built by repeated q0.32 decay steps
  function automatic k_tab_t build_k_tab();
    logic [95:0] p;
    logic [95:0] one;
    k_tab_t      t;
    one = 96'd1 << 32;
    p   = one;
    for (int ms = 0; ms <= MS_CAP; ms++) begin
      t[ms] = KW'((one - p + 96'd32768) >> 16);
      p = (p * 96'(VU_DECAY_Q32) + (96'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  // fall per tick, tenths of full scale per second
  function automatic fall_tab_t build_fall_tab(input int unsigned tenths);
    logic [63:0] num;
    fall_tab_t   t;
    for (int ms = 0; ms <= MS_CAP; ms++) begin
      num   = 64'(ms) * 64'(tenths) * 64'(FULL_SCALE) + 64'd5000;
      t[ms] = LEVEL_BITS'(num / 64'd10000);
    end
    return t;
  endfunction

  localparam k_tab_t    VU_K_TAB       = build_k_tab();
  localparam fall_tab_t HOLD_FALL_TAB  = build_fall_tab(8);
  localparam fall_tab_t PEAK_FALL_TAB  = build_fall_tab(3);

  // q0.16 break point aligned to the level width
  function automatic level_t align_break(input logic [BREAK_W-1:0] b);
    logic [LEVEL_BITS+BREAK_W-1:0] w;
    w = (LEVEL_BITS + BREAK_W)'(b) << LEVEL_BITS;
    return w[LEVEL_BITS+BREAK_W-1:BREAK_W];
  endfunction

endpackage

`default_nettype wire

/* src/level_meter_ballistics.sv */
// a beat is written into the queue, then taken into the state registers of lmb_back
// throughput: one beat per cycle while the result is not stalled, set by the state update in lmb_back
// a two-entry queue lets input keep flowing for two beats while the result is stalled
// reset (rst, synchronous): clears levels, queue and valid flags, and loads the
// register defaults (mode exact, peak off, one zone, all breaks zero)
// ----------------------------------------------------------------------------
// level_meter_ballistics
// panel level meter with exact, vu or peak-hold ballistics, a decaying peak marker
// and zone lookup; front decodes beats, back updates the meter state
// ----------------------------------------------------------------------------
`default_nettype none

module level_meter_ballistics (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration writes
  input  wire logic                         cfg_write,
  input  wire logic [lmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lmb_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   op,
  input  wire logic [15:0]                  value,
  input  wire logic [lmb_pkg::MS_W-1:0]     elapsed_ms,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lmb_pkg::LEVEL_BITS-1:0]    level,
  output logic [lmb_pkg::LEVEL_BITS-1:0]    peak_level,
  output logic [lmb_pkg::ZONE_W-1:0]        zone
);

  // register file; the user must write only while the meter is idle (not enforced)
  lmb_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= lmb_pkg::MODE_EXACT;
      cfg.peak_enable <= 1'b0;
      cfg.zone_count  <= lmb_pkg::ZC_W'(1);
      cfg.breaks_low  <= '0;
      cfg.breaks_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lmb_pkg::CFG_MODE:        cfg.mode        <= cfg_data[1:0];
        lmb_pkg::CFG_PEAK_ENABLE: cfg.peak_enable <= cfg_data[0];
        lmb_pkg::CFG_ZONE_COUNT:  cfg.zone_count  <= cfg_data[lmb_pkg::ZC_W-1:0];
        lmb_pkg::CFG_BREAKS_LOW:  cfg.breaks_low  <= cfg_data[lmb_pkg::BRK_LOW_W-1:0];
        lmb_pkg::CFG_BREAKS_HIGH: cfg.breaks_high <= cfg_data[lmb_pkg::BRK_HIGH_W-1:0];
        default: begin
          // unknown index: write is dropped
        end
      endcase
    end
  end

  // front to queue
  lmb_pkg::item_t front_item;
  logic           push;
  logic           queue_full;

  // queue to back
  lmb_pkg::item_t head_item;
  logic           queue_avail;
  logic           pop;

  // decode op, saturate ms and look up vu factor and fall steps
  lmb_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .elapsed_ms (elapsed_ms),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item)
  );

  // decouples input acceptance from a stalled result
  lmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .full      (queue_full),
    .not_empty (queue_avail)
  );

  // one beat per cycle unless the result stalls: ballistics update, peak marker, zone
  lmb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (head_item),
    .avail      (queue_avail),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .level      (level),
    .peak_level (peak_level),
    .zone       (zone)
  );

endmodule

`default_nettype wire

/* src/lmb_front.sv */
// ----------------------------------------------------------------------------
// lmb_front
// takes input beats, decodes the op and looks up ballistics factors
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_front (
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              op,
  input  wire logic [15:0]             value,
  input  wire logic [lmb_pkg::MS_W-1:0] elapsed_ms,
  input  wire logic                    queue_full,
  output logic                         push,
  output lmb_pkg::item_t               item
);

  logic [lmb_pkg::MS_IDX_W-1:0] ms_sat;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // saturate to the table range
  always_comb begin
    if (elapsed_ms > lmb_pkg::MS_W'(lmb_pkg::MS_CAP)) begin
      ms_sat = lmb_pkg::MS_IDX_W'(lmb_pkg::MS_CAP);
    end else begin
      ms_sat = elapsed_ms[lmb_pkg::MS_IDX_W-1:0];
    end
  end

  always_comb begin
    item.op         = lmb_pkg::op_t'(op);
    item.val        = lmb_pkg::LEVEL_BITS'(value);
    item.tick_nz    = (ms_sat != '0);
    item.k          = lmb_pkg::VU_K_TAB[ms_sat];
    item.fall_level = lmb_pkg::HOLD_FALL_TAB[ms_sat];
    item.fall_peak  = lmb_pkg::PEAK_FALL_TAB[ms_sat];
  end

endmodule

`default_nettype wire

/* src/lmb_queue.sv */
// ----------------------------------------------------------------------------
// lmb_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "level_meter_ballistics_defines.svh"

module lmb_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  lmb_pkg::item_t      push_item,
  input  wire logic           pop,
  output lmb_pkg::item_t      head_item,
  output logic                full,
  output logic                not_empty
);

  lmb_pkg::item_t mem [0:1];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `LMB_ASSERT_NOW(a_no_overflow, push, count != 2'd2)
  `LMB_ASSERT_NOW(a_no_underflow, pop, count != 2'd0)

endmodule

`default_nettype wire

/* src/lmb_back.sv */
// ----------------------------------------------------------------------------
// lmb_back
// meter state update, result register and zone lookup
// ----------------------------------------------------------------------------
`default_nettype none

`include "level_meter_ballistics_defines.svh"

module lmb_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  lmb_pkg::cfg_t                  cfg,
  input  lmb_pkg::item_t                 item,
  input  wire logic                      avail,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output lmb_pkg::level_t                level,
  output lmb_pkg::level_t                peak_level,
  output logic [lmb_pkg::ZONE_W-1:0]     zone
);

  localparam int PW = lmb_pkg::LEVEL_BITS + lmb_pkg::KW;

  lmb_pkg::level_t target_level, target_level_next;
  lmb_pkg::level_t shown_level, shown_level_next;
  lmb_pkg::level_t peak_hold, peak_hold_next;

  lmb_pkg::level_t diff;
  logic            rising;
  logic [PW-1:0]   prod;
  logic [PW:0]     prod_rnd;
  lmb_pkg::level_t step;
  lmb_pkg::level_t tick_level;
  lmb_pkg::level_t tick_peak;
  lmb_pkg::level_t peak_gap;
  logic            exact_mode;

  assign pop = avail && (!out_valid || !out_stall);

  // state registers double as the result register
  assign level      = shown_level;
  assign peak_level = peak_hold;

  assign exact_mode = cfg.mode inside {lmb_pkg::MODE_EXACT, lmb_pkg::MODE_EXACT_ALT};

  // vu step
  assign rising   = (target_level >= shown_level);
  assign diff     = rising ? (target_level - shown_level) : (shown_level - target_level);
  assign prod     = PW'(diff) * PW'(item.k);
  assign prod_rnd = {1'b0, prod} + (PW + 1)'(1 << lmb_pkg::ROUND_POS);
  assign step     = prod_rnd[lmb_pkg::LEVEL_BITS+15:16];

  always_comb begin
    if (cfg.mode == lmb_pkg::MODE_VU && item.tick_nz) begin
      tick_level = rising ? (shown_level + step) : (shown_level - step);
    end else if (cfg.mode == lmb_pkg::MODE_HOLD && item.tick_nz) begin
      if (rising || item.fall_level >= diff) begin
        tick_level = target_level;
      end else begin
        tick_level = shown_level - item.fall_level;
      end
    end else begin
      tick_level = target_level;
    end
  end

  assign peak_gap = peak_hold - tick_level;

  always_comb begin
    if (!cfg.peak_enable || tick_level >= peak_hold) begin
      tick_peak = tick_level;
    end else if (!item.tick_nz) begin
      tick_peak = peak_hold;
    end else if (item.fall_peak >= peak_gap) begin
      tick_peak = tick_level;
    end else begin
      tick_peak = peak_hold - item.fall_peak;
    end
  end

  always_comb begin
    target_level_next = target_level;
    shown_level_next  = shown_level;
    peak_hold_next    = peak_hold;
    case (item.op)
      lmb_pkg::OP_SET: begin
        target_level_next = item.val;
        if (exact_mode) begin
          shown_level_next = item.val;
          if (!cfg.peak_enable || item.val > peak_hold) begin
            peak_hold_next = item.val;
          end
        end
      end
      lmb_pkg::OP_TICK: begin
        shown_level_next = tick_level;
        peak_hold_next   = tick_peak;
      end
      lmb_pkg::OP_PEAK_RESET: begin
        peak_hold_next = shown_level;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= '0;
      shown_level  <= '0;
      peak_hold    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        target_level <= target_level_next;
        shown_level  <= shown_level_next;
        peak_hold    <= peak_hold_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // zone: leading breaks at or below the level, limited by the zone count
  logic [lmb_pkg::ZC_W-1:0]   zc;
  logic [lmb_pkg::ZC_W-1:0]   brk_used;
  logic [lmb_pkg::BRK_HIGH_W+lmb_pkg::BRK_LOW_W-1:0] brk_all;
  logic [lmb_pkg::ZONE_W-1:0] zone_cnt;
  logic                       run;

  always_comb begin
    if (cfg.zone_count == '0) begin
      zc = lmb_pkg::ZC_W'(1);
    end else if (cfg.zone_count > lmb_pkg::ZC_W'(lmb_pkg::MAX_ZONES)) begin
      zc = lmb_pkg::ZC_W'(lmb_pkg::MAX_ZONES);
    end else begin
      zc = cfg.zone_count;
    end
    brk_used = zc - lmb_pkg::ZC_W'(1);
    brk_all  = {cfg.breaks_high, cfg.breaks_low};
    run      = 1'b1;
    zone_cnt = '0;
    for (int j = 0; j < lmb_pkg::NUM_BREAKS; j++) begin
      run = run && (lmb_pkg::ZC_W'(j) < brk_used)
            && (shown_level >= lmb_pkg::align_break(brk_all[16*j +: 16]));
      zone_cnt = zone_cnt + lmb_pkg::ZONE_W'(run);
    end
  end

  assign zone = zone_cnt;

  `LMB_ASSERT_NOW(a_peak_not_below_level, 1'b1, peak_hold >= shown_level)
  `LMB_ASSERT_NOW(a_result_drop_only_taken, $fell(out_valid), $past(!out_stall))

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: level meter ballistics testbench
// drives set, tick, peak-reset and no-op beats over the valid/stall handshake,
// predicts level, peak and zone for every accepted beat and checks each
// result beat in order, across exact, vu, peak-hold and alternate modes
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CYCLE_LIMIT = 200000;

  // one expected result beat
  typedef struct packed {
    lmb_pkg::level_t level;
    lmb_pkg::level_t peak;
    logic [2:0]      zone;
  } meter_out_t;

  // scoreboard: own copy of the meter state and registers, plus the queue
  // of results still owed by the block
  class level_scoreboard;
    logic [1:0]      mode;
    logic            peak_on;
    logic [3:0]      zone_count;
    logic [63:0]     brk_lo;
    logic [47:0]     brk_hi;
    lmb_pkg::level_t target;
    lmb_pkg::level_t shown;
    lmb_pkg::level_t peak;
    meter_out_t      owed_q[$];
    int              errors;

    function new();
      mode       = lmb_pkg::MODE_EXACT;
      peak_on    = 1'b0;
      zone_count = 4'd1;
      brk_lo     = '0;
      brk_hi     = '0;
      target     = '0;
      shown      = '0;
      peak       = '0;
      errors     = 0;
    endfunction

    function void note_reg(logic [lmb_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        lmb_pkg::CFG_MODE:        mode       = data[1:0];
        lmb_pkg::CFG_PEAK_ENABLE: peak_on    = data[0];
        lmb_pkg::CFG_ZONE_COUNT:  zone_count = data[3:0];
        lmb_pkg::CFG_BREAKS_LOW:  brk_lo     = data;
        lmb_pkg::CFG_BREAKS_HIGH: brk_hi     = data[47:0];
        default: ;
      endcase
    endfunction

    // fall over ms milliseconds at tenths of full scale per second, rounded
    function logic [31:0] fall_by(int unsigned ms, int unsigned tenths);
      return 32'((64'(ms) * 64'(tenths) * 64'(lmb_pkg::FULL_SCALE) + 64'd5000) / 64'd10000);
    endfunction

    function void note_beat(lmb_pkg::op_t o, lmb_pkg::level_t val,
                            logic [lmb_pkg::MS_W-1:0] ms_in);
      longint unsigned p;
      longint unsigned k;
      longint unsigned lvl_gap;
      int unsigned     ms;
      int unsigned     zc;
      int unsigned     nz;
      logic [31:0]     fall;
      logic [15:0]     brk;
      meter_out_t      r;
      ms = (ms_in > lmb_pkg::MS_CAP) ? lmb_pkg::MS_CAP : ms_in;
      case (o)
        lmb_pkg::OP_SET: begin
          target = val;
          if (mode == lmb_pkg::MODE_EXACT || mode == lmb_pkg::MODE_EXACT_ALT) begin
            shown = val;
            if (peak_on) begin
              if (val > peak) peak = val;
            end else begin
              peak = val;
            end
          end
        end
        lmb_pkg::OP_TICK: begin
          if (mode == lmb_pkg::MODE_VU && ms > 0) begin
            // k = 1 - exp(-ms/65) by repeated q0.32 decay steps
            p = 64'd1 << 32;
            for (int i = 0; i < ms; i++)
              p = (p * lmb_pkg::VU_DECAY_Q32 + (64'd1 << 31)) >> 32;
            k = ((64'd1 << 32) - p + (64'd1 << 15)) >> 16;
            if (target >= shown) begin
              lvl_gap = target - shown;
              shown   = shown + lmb_pkg::level_t'((lvl_gap * k + 64'd32768) >> 16);
            end else begin
              lvl_gap = shown - target;
              shown   = shown - lmb_pkg::level_t'((lvl_gap * k + 64'd32768) >> 16);
            end
          end else if (mode == lmb_pkg::MODE_HOLD && ms > 0) begin
            if (target >= shown) begin
              shown = target;
            end else begin
              fall = fall_by(ms, 8);
              if (fall >= 32'(shown - target)) shown = target;
              else shown = shown - lmb_pkg::level_t'(fall);
            end
          end else begin
            shown = target;
          end
          if (peak_on) begin
            if (shown >= peak) begin
              peak = shown;
            end else if (ms > 0) begin
              fall = fall_by(ms, 3);
              if (fall >= 32'(peak - shown)) peak = shown;
              else peak = peak - lmb_pkg::level_t'(fall);
            end
          end else begin
            peak = shown;
          end
        end
        lmb_pkg::OP_PEAK_RESET: peak = shown;
        default: ;
      endcase
      // zone: leading breaks at or below the level, capped by the zone count
      zc = zone_count;
      if (zc < 1) zc = 1;
      if (zc > lmb_pkg::MAX_ZONES) zc = lmb_pkg::MAX_ZONES;
      nz = 0;
      while (nz < zc - 1) begin
        if (nz < 4) brk = brk_lo[16*nz +: 16];
        else brk = brk_hi[16*(nz-4) +: 16];
        if (shown < brk) break;
        nz++;
      end
      r.level = shown;
      r.peak  = peak;
      r.zone  = nz[2:0];
      owed_q.push_back(r);
    endfunction

    function void check_beat(lmb_pkg::level_t lvl, lmb_pkg::level_t pk, logic [2:0] z);
      meter_out_t e;
      if (owed_q.size() == 0) begin
        $error("result beat with no expectation: level %0d peak %0d zone %0d", lvl, pk, z);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (lvl !== e.level) begin
        $error("level mismatch: expected %0d, actual %0d", e.level, lvl);
        errors++;
      end
      if (pk !== e.peak) begin
        $error("peak_level mismatch: expected %0d, actual %0d", e.peak, pk);
        errors++;
      end
      if (z !== e.zone) begin
        $error("zone mismatch: expected %0d, actual %0d", e.zone, z);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // dut signals, all inputs known from time zero
  logic                               clk        = 1'b0;
  logic                               rst        = 1'b1;
  logic                               cfg_write  = 1'b0;
  logic [lmb_pkg::CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [lmb_pkg::CFG_DATA_W-1:0]     cfg_data   = '0;
  logic                               in_valid   = 1'b0;
  logic                               in_stall;
  logic [1:0]                         op         = '0;
  logic [15:0]                        value      = '0;
  logic [lmb_pkg::MS_W-1:0]           elapsed_ms = '0;
  logic                               out_valid;
  logic                               out_stall  = 1'b0;
  logic [lmb_pkg::LEVEL_BITS-1:0]     level;
  logic [lmb_pkg::LEVEL_BITS-1:0]     peak_level;
  logic [lmb_pkg::ZONE_W-1:0]         zone;

  level_scoreboard meter_sb = new();
  int              cycle_count = 0;
  bit              calm = 1'b0;   // no idling on either side while set

  always #4 clk = ~clk;

  level_meter_ballistics u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .elapsed_ms (elapsed_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .level      (level),
    .peak_level (peak_level),
    .zone       (zone)
  );

  // receiver back-pressure, changed only at the falling edge
  always @(negedge clk) begin
    out_stall = calm ? 1'b0 : ($urandom_range(99) < 31);
  end

  // result monitor: a beat moves at a rising edge with valid high and stall low
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      meter_sb.check_beat(level, peak_level, zone);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // present one beat, with random gaps ahead of it, and hold it until taken
  task automatic send_beat(lmb_pkg::op_t o, lmb_pkg::level_t v,
                           logic [lmb_pkg::MS_W-1:0] ms);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    op         = o;
    value      = v;
    elapsed_ms = ms;
    do @(posedge clk); while (in_stall);
    meter_sb.note_beat(o, v, ms);
  endtask

  // stop sending and let every owed result come back
  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (meter_sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [lmb_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    meter_sb.note_reg(idx, data);
  endtask

  // registers change only with the block drained
  task automatic configure(logic [1:0] m, logic pen, logic [3:0] zc,
                           logic [63:0] lo, logic [47:0] hi);
    wait_results();
    write_reg(lmb_pkg::CFG_MODE, 64'(m));
    write_reg(lmb_pkg::CFG_PEAK_ENABLE, 64'(pen));
    write_reg(lmb_pkg::CFG_ZONE_COUNT, 64'(zc));
    write_reg(lmb_pkg::CFG_BREAKS_LOW, lo);
    write_reg(lmb_pkg::CFG_BREAKS_HIGH, 64'(hi));
  endtask

  // mostly sets and ticks so the ballistics get exercised, some peak resets
  // and a little no-op noise; unused fields always carry random bits
  task automatic random_beats(int n);
    int                       r;
    lmb_pkg::op_t             o;
    lmb_pkg::level_t          v;
    logic [lmb_pkg::MS_W-1:0] ms;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      v  = lmb_pkg::level_t'($urandom);
      ms = lmb_pkg::MS_W'($urandom);
      if (r < 40) begin
        o = lmb_pkg::OP_SET;
        case ($urandom_range(9))
          0: v = '0;
          1: v = lmb_pkg::FULL_SCALE;
          default: ;
        endcase
      end else if (r < 88) begin
        o = lmb_pkg::OP_TICK;
        r = $urandom_range(99);
        if (r < 10) ms = '0;
        else if (r >= 25) ms = lmb_pkg::MS_W'($urandom_range(lmb_pkg::MS_CAP, 1));
      end else if (r < 96) begin
        o = lmb_pkg::OP_PEAK_RESET;
      end else begin
        o = lmb_pkg::OP_NOP;
      end
      // occasional hold-off until the pipe is empty
      if ($urandom_range(299) == 0) wait_results();
      send_beat(o, v, ms);
    end
  endtask

  initial begin
    logic [1:0]  m;
    logic        pen;
    logic [3:0]  zc;
    logic [63:0] lo;
    logic [47:0] hi;
    int unsigned acc;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // exact mode, peak marker on, full set of ascending breaks
    configure(lmb_pkg::MODE_EXACT, 1'b1, 4'd8, 64'h8000_5000_3000_1000,
              48'hF000_C000_A000);
    send_beat(lmb_pkg::OP_SET, 16'h0000, '0);
    send_beat(lmb_pkg::OP_SET, 16'hFFFF, '0);
    send_beat(lmb_pkg::OP_SET, 16'h8000, '0);
    send_beat(lmb_pkg::OP_SET, 16'h0FFF, '0);       // just under the first break
    send_beat(lmb_pkg::OP_SET, 16'h1000, '0);       // exactly on the first break
    send_beat(lmb_pkg::OP_TICK, 16'h0000, '0);      // zero-ms tick
    send_beat(lmb_pkg::OP_PEAK_RESET, 16'h0000, '0);
    send_beat(lmb_pkg::OP_NOP, 16'hFFFF, 10'h3FF);  // no-op reports state only

    // vu ballistics, including ms saturation
    configure(lmb_pkg::MODE_VU, 1'b1, 4'd8, 64'h8000_5000_3000_1000,
              48'hF000_C000_A000);
    send_beat(lmb_pkg::OP_SET, 16'hFFFF, '0);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'd1);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'd100);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'h3FF);
    send_beat(lmb_pkg::OP_SET, 16'h0000, '0);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'd65);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, '0);

    // peak-hold with slow fall, zone count above the maximum
    configure(lmb_pkg::MODE_HOLD, 1'b1, 4'd15, 64'h8000_5000_3000_1000,
              48'hF000_C000_A000);
    send_beat(lmb_pkg::OP_SET, 16'hFFFF, '0);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'd5);
    send_beat(lmb_pkg::OP_SET, 16'h0000, '0);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'd10);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'd100);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, '0);

    // alternate exact code, peak follows level, unordered breaks
    configure(lmb_pkg::MODE_EXACT_ALT, 1'b0, 4'd8, 64'h2000_9000_4000_1000,
              48'h0100_FFFF_0000);
    send_beat(lmb_pkg::OP_SET, 16'h9000, '0);
    send_beat(lmb_pkg::OP_TICK, 16'h0000, 10'd1);
    send_beat(lmb_pkg::OP_PEAK_RESET, 16'h0000, '0);

    // random phases over every mode and zone-count extreme
    for (int ph = 0; ph < 9; ph++) begin
      m   = 2'(ph % 4);
      pen = 1'($urandom);
      case (ph)
        0: zc = 4'd0;
        1: zc = 4'd1;
        2: zc = 4'd8;
        3: zc = 4'd15;
        default: zc = 4'($urandom_range(15));
      endcase
      if (ph == 4) begin
        lo = '0;
        hi = '0;
      end else if (ph == 5) begin
        lo = '1;
        hi = '1;
      end else if ($urandom_range(1) == 0) begin
        // ascending breaks with random spacing
        acc = 0;
        for (int b = 0; b < lmb_pkg::NUM_BREAKS; b++) begin
          acc = acc + $urandom_range(9362);
          if (b < 4) lo[16*b +: 16] = 16'(acc);
          else hi[16*(b-4) +: 16] = 16'(acc);
        end
      end else begin
        lo = {$urandom, $urandom};
        hi = {16'($urandom), $urandom};
      end
      configure(m, pen, zc, lo, hi);
      calm = (ph == 6);
      random_beats(100);
      calm = 1'b0;
    end

    wait_results();
    repeat (8) @(negedge clk);
    if (meter_sb.pending() != 0)
      $error("%0d expected results never arrived", meter_sb.pending());
    if (meter_sb.errors == 0 && meter_sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/lmb_pkg.sv
src/lmb_front.sv
src/lmb_queue.sv
src/lmb_back.sv
src/level_meter_ballistics.sv
bench/tb_top.sv
